### design/rls_pkg.sv
package rls_pkg;

  // Field and accumulator widths.
  localparam int unsigned CountBits = 16;
  localparam int unsigned RttBits   = 24;
  localparam int unsigned SumBits   = 40;
  localparam int unsigned SqBits    = 64;
  localparam int unsigned ProdBits  = 2 * RttBits;
  localparam int unsigned LossBits  = 14;

  // Saturation limit of the probe count.
  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

  // Loss is reported in hundredths of a percent.
  localparam logic [LossBits-1:0] LossScale = 14'd10000;

  // Loss dividend length, dividend register width and step counter width, in bits.
  localparam int unsigned LossNumBits = CountBits + LossBits;
  localparam int unsigned DivBits     = SqBits;
  localparam int unsigned CntBits     = 7;

  // Input operation codes.
  localparam logic OpSample = 1'b0;
  localparam logic OpClear  = 1'b1;

  // Statistics snapshot passed from the front to the back.
  typedef struct packed {
    logic [CountBits-1:0] sent;
    logic [CountBits-1:0] recv;
    logic [SumBits-1:0]   sum;
    logic [SqBits-1:0]    sumsq;
    logic [RttBits-1:0]   min_rtt;
    logic [RttBits-1:0]   max_rtt;
    logic                 last_valid;
    logic [RttBits-1:0]   last_rtt;
    logic                 ovf;
  } snap_t;

  // One finished result.
  typedef struct packed {
    logic [CountBits-1:0] sent;
    logic [CountBits-1:0] recv;
    logic [LossBits-1:0]  loss;
    logic                 latest_valid;
    logic [RttBits-1:0]   latest_rtt;
    logic                 stats_valid;
    logic [RttBits-1:0]   min_rtt;
    logic [RttBits-1:0]   max_rtt;
    logic [RttBits-1:0]   mean_rtt;
    logic [RttBits-1:0]   std_rtt;
    logic                 saturated;
  } res_t;

  // Back-end sequencer states.
  typedef enum logic [7:0] {
    B_IDLE = 8'b0000_0001,
    B_LOSS = 8'b0000_0010,
    B_MEAN = 8'b0000_0100,
    B_SQM  = 8'b0000_1000,
    B_MUL  = 8'b0001_0000,
    B_SUB  = 8'b0010_0000,
    B_SQRT = 8'b0100_0000,
    B_DONE = 8'b1000_0000
  } bstate_e;

endpackage

### design/rls_front.sv
module rls_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic                       op_i,
  input  logic                       rtt_valid_i,
  input  logic [23:0]                rtt_us_i,
  input  logic                       q_full_i,
  output logic                       q_push_o,
  output rls_pkg::snap_t             q_data_o
);

  logic [rls_pkg::CountBits-1:0] sent_q, recv_q;
  logic [rls_pkg::SumBits-1:0]   sum_q;
  logic [rls_pkg::SqBits-1:0]    sumsq_q, sumsq_d;
  logic [rls_pkg::RttBits-1:0]   min_q, max_q, lastr_q, rtt;
  logic                          lastv_q, ovf_q, busy_q, accept;
  logic [rls_pkg::ProdBits-1:0]  prod_q;

  // A request is taken when the square of the last one has been folded in
  // and the queue has room for its snapshot.
  assign full   = busy_q | q_full_i;
  assign accept = push & ~full;
  assign rtt    = rtt_us_i[rls_pkg::RttBits-1:0];

  // The square is registered with the request and added in the cycle after, as the snapshot leaves.
  assign sumsq_d  = sumsq_q + rls_pkg::SqBits'(prod_q);
  assign q_push_o = busy_q;

  always_comb begin
    q_data_o            = '0;
    q_data_o.sent       = sent_q;
    q_data_o.recv       = recv_q;
    q_data_o.sum        = sum_q;
    q_data_o.sumsq      = sumsq_d;
    q_data_o.min_rtt    = min_q;
    q_data_o.max_rtt    = max_q;
    q_data_o.last_valid = lastv_q;
    q_data_o.last_rtt   = lastr_q;
    q_data_o.ovf        = ovf_q;
  end

  // Accumulator update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_q  <= '0;
      recv_q  <= '0;
      sum_q   <= '0;
      sumsq_q <= '0;
      min_q   <= '0;
      max_q   <= '0;
      lastv_q <= 1'b0;
      lastr_q <= '0;
      ovf_q   <= 1'b0;
      prod_q  <= '0;
      busy_q  <= 1'b0;
    end else begin
      if (busy_q) begin
        sumsq_q <= sumsq_d;
        busy_q  <= 1'b0;
      end
      if (accept) begin
        busy_q <= 1'b1;
        prod_q <= '0;
        if (op_i == rls_pkg::OpClear) begin
          sent_q  <= '0;
          recv_q  <= '0;
          sum_q   <= '0;
          sumsq_q <= '0;
          min_q   <= '0;
          max_q   <= '0;
          lastv_q <= 1'b0;
          lastr_q <= '0;
          ovf_q   <= 1'b0;
        end else if (sent_q < rls_pkg::CountMax) begin
          sent_q <= sent_q + 1'b1;
          if (sent_q + 1'b1 == rls_pkg::CountMax) begin
            ovf_q <= 1'b1;
          end
          if (rtt_valid_i) begin
            if (recv_q == '0) begin
              min_q <= rtt;
              max_q <= rtt;
            end else begin
              if (rtt < min_q) min_q <= rtt;
              if (rtt > max_q) max_q <= rtt;
            end
            recv_q  <= recv_q + 1'b1;
            sum_q   <= sum_q + rls_pkg::SumBits'(rtt);
            prod_q  <= rtt * rtt;
            lastv_q <= 1'b1;
            lastr_q <= rtt;
          end else begin
            lastv_q <= 1'b0;
            lastr_q <= '0;
          end
        end
      end
    end
  end

endmodule

### design/rls_queue.sv
module rls_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rls_pkg::snap_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output rls_pkg::snap_t data_o
);

  rls_pkg::snap_t entry_q [2];
  logic           wr_q, rd_q;
  logic [1:0]     cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = entry_q[rd_q];

  // Two-entry circular buffer of snapshots.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q       <= 1'b0;
      rd_q       <= 1'b0;
      cnt_q      <= '0;
      entry_q[0] <= '0;
      entry_q[1] <= '0;
    end else begin
      if (push_i) begin
        entry_q[wr_q] <= data_i;
        wr_q          <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

### design/rls_back.sv
module rls_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  input  rls_pkg::snap_t q_data_i,
  output logic           q_pop_o,
  input  logic           pop,
  output logic           empty,
  output rls_pkg::res_t  res_o
);

  rls_pkg::bstate_e              state_q;
  rls_pkg::snap_t                snap_q;
  rls_pkg::res_t                 res_q;
  logic                          res_valid_q, res_load;
  logic [rls_pkg::DivBits-1:0]   dvd_q, dvd_nx;
  logic [rls_pkg::CountBits-1:0] dsr_q, rem_q, rem_nx;
  logic [rls_pkg::CountBits:0]   rem_sh;
  logic                          ge;
  logic [rls_pkg::CntBits-1:0]   cnt_q;
  logic                          last;
  logic [rls_pkg::LossBits-1:0]  loss_q;
  logic [rls_pkg::RttBits-1:0]   mean_q, root_q;
  logic [rls_pkg::ProdBits-1:0]  sqm_q, msq_q, rv_q;
  logic [rls_pkg::RttBits+1:0]   srem_q;
  logic [rls_pkg::RttBits+3:0]   srem_sh, trial;
  logic                          sge;
  logic [rls_pkg::LossNumBits-1:0] loss_num;
  logic                          sv;

  // One restoring division step, a quotient bit per cycle.
  assign rem_sh = {rem_q, dvd_q[rls_pkg::DivBits-1]};
  assign ge     = rem_sh >= {1'b0, dsr_q};
  assign rem_nx = ge ? rls_pkg::CountBits'(rem_sh - {1'b0, dsr_q})
                     : rem_sh[rls_pkg::CountBits-1:0];
  assign dvd_nx = {dvd_q[rls_pkg::DivBits-2:0], ge};
  assign last   = cnt_q == rls_pkg::CntBits'(1);

  // One square root step, a root bit per cycle.
  assign srem_sh = {srem_q, rv_q[rls_pkg::ProdBits-1 -: 2]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign sge     = srem_sh >= trial;

  // Numerator of the loss figure, taken from the queue head.
  assign loss_num = (q_data_i.sent - q_data_i.recv) * rls_pkg::LossScale;

  assign q_pop_o  = (state_q == rls_pkg::B_IDLE) && !q_empty_i;
  assign empty    = ~res_valid_q;
  assign res_o    = res_q;
  assign res_load = (state_q == rls_pkg::B_DONE) && (!res_valid_q || pop);
  assign sv       = snap_q.recv != '0;

  // Sequencer over the three divisions and the square root.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rls_pkg::B_IDLE;
      snap_q      <= '0;
      res_q       <= '0;
      res_valid_q <= 1'b0;
      dvd_q       <= '0;
      dsr_q       <= '0;
      rem_q       <= '0;
      cnt_q       <= '0;
      loss_q      <= '0;
      mean_q      <= '0;
      sqm_q       <= '0;
      msq_q       <= '0;
      rv_q        <= '0;
      srem_q      <= '0;
      root_q      <= '0;
    end else begin
      // A new result replaces the one taken in the same cycle.
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (pop) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        rls_pkg::B_IDLE: begin
          if (!q_empty_i) begin
            snap_q  <= q_data_i;
            dvd_q   <= {loss_num, {(rls_pkg::DivBits-rls_pkg::LossNumBits){1'b0}}};
            dsr_q   <= q_data_i.sent;
            rem_q   <= '0;
            cnt_q   <= rls_pkg::CntBits'(rls_pkg::LossNumBits);
            state_q <= rls_pkg::B_LOSS;
          end
        end
        rls_pkg::B_LOSS: begin
          if (last) begin
            loss_q  <= dvd_nx[rls_pkg::LossBits-1:0];
            dvd_q   <= {snap_q.sum, {(rls_pkg::DivBits-rls_pkg::SumBits){1'b0}}};
            dsr_q   <= snap_q.recv;
            rem_q   <= '0;
            cnt_q   <= rls_pkg::CntBits'(rls_pkg::SumBits);
            state_q <= rls_pkg::B_MEAN;
          end else begin
            dvd_q <= dvd_nx;
            rem_q <= rem_nx;
            cnt_q <= cnt_q - 1'b1;
          end
        end
        rls_pkg::B_MEAN: begin
          if (last) begin
            mean_q  <= dvd_nx[rls_pkg::RttBits-1:0];
            dvd_q   <= snap_q.sumsq;
            rem_q   <= '0;
            cnt_q   <= rls_pkg::CntBits'(rls_pkg::SqBits);
            state_q <= rls_pkg::B_SQM;
          end else begin
            dvd_q <= dvd_nx;
            rem_q <= rem_nx;
            cnt_q <= cnt_q - 1'b1;
          end
        end
        rls_pkg::B_SQM: begin
          if (last) begin
            sqm_q   <= dvd_nx[rls_pkg::ProdBits-1:0];
            state_q <= rls_pkg::B_MUL;
          end else begin
            dvd_q <= dvd_nx;
            rem_q <= rem_nx;
            cnt_q <= cnt_q - 1'b1;
          end
        end
        rls_pkg::B_MUL: begin
          msq_q   <= mean_q * mean_q;
          state_q <= rls_pkg::B_SUB;
        end
        rls_pkg::B_SUB: begin
          // A negative difference from truncation is clamped to zero.
          rv_q    <= (sqm_q > msq_q) ? sqm_q - msq_q : '0;
          srem_q  <= '0;
          root_q  <= '0;
          cnt_q   <= rls_pkg::CntBits'(rls_pkg::RttBits);
          state_q <= rls_pkg::B_SQRT;
        end
        rls_pkg::B_SQRT: begin
          srem_q <= sge ? (rls_pkg::RttBits+2)'(srem_sh - trial)
                        : srem_sh[rls_pkg::RttBits+1:0];
          root_q <= {root_q[rls_pkg::RttBits-2:0], sge};
          rv_q   <= {rv_q[rls_pkg::ProdBits-3:0], 2'b00};
          cnt_q  <= cnt_q - 1'b1;
          if (last) begin
            state_q <= rls_pkg::B_DONE;
          end
        end
        rls_pkg::B_DONE: begin
          if (res_load) begin
            res_q.sent         <= snap_q.sent;
            res_q.recv         <= snap_q.recv;
            res_q.loss         <= (snap_q.sent != '0) ? loss_q : '0;
            res_q.latest_valid <= snap_q.last_valid;
            res_q.latest_rtt   <= snap_q.last_rtt;
            res_q.stats_valid  <= sv;
            res_q.min_rtt      <= sv ? snap_q.min_rtt : '0;
            res_q.max_rtt      <= sv ? snap_q.max_rtt : '0;
            res_q.mean_rtt     <= sv ? mean_q : '0;
            res_q.std_rtt      <= sv ? root_q : '0;
            res_q.saturated    <= snap_q.ovf;
            state_q            <= rls_pkg::B_IDLE;
          end
        end
        default: begin
          state_q <= rls_pkg::B_IDLE;
        end
      endcase
    end
  end

endmodule

### design/rtt_loss_statistics.sv
// Per-hop probe statistics.
// Input requests arrive through push / full: a request is taken at a rising
// edge with push high and full low. Each carries a probe sample (a reply
// time or a loss) or a clear of all history.
// Results leave through empty / pop: while empty is low the oldest result
// stands on the result ports and is taken at an edge with pop high.
// Every request gives exactly one result: counts, loss in hundredths of a
// percent, latest reply, minimum, maximum, truncated mean and deviation.
// The front updates the running sums in two steps per request (square,
// then accumulate), takes the next request only after both, and passes
// a snapshot into a two-entry queue. The back works each snapshot
// through one shared bit-serial divider (loss, mean, mean square) and
// a bit-serial square root, one snapshot at a time, and so sets the
// sustained rate. Each result then waits in the back's result register.
// While the receiver stalls, one result waits in the output register, the
// back holds its next result, and the queue fills; then full rises.
// Reset clears all history and leaves the block empty and ready.
module rtt_loss_statistics (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        op_i,
  input  logic        rtt_valid_i,
  input  logic [23:0] rtt_us_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] sent_count_o,
  output logic [15:0] recv_count_o,
  output logic [13:0] loss_centi_pct_o,
  output logic        latest_valid_o,
  output logic [23:0] latest_rtt_o,
  output logic        stats_valid_o,
  output logic [23:0] min_rtt_o,
  output logic [23:0] max_rtt_o,
  output logic [23:0] mean_rtt_o,
  output logic [23:0] std_rtt_o,
  output logic        saturated_o
);

  rls_pkg::snap_t push_data, head_data;
  rls_pkg::res_t  res;
  logic           q_push, q_pop, q_full, q_empty;

  // Front: accept requests and update the running sums.
  rls_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .op_i        (op_i),
    .rtt_valid_i (rtt_valid_i),
    .rtt_us_i    (rtt_us_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (push_data)
  );

  // Snapshot queue between the two halves.
  rls_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (push_data),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (head_data)
  );

  // Back: divisions, square root and the result register.
  rls_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (head_data),
    .q_pop_o   (q_pop),
    .pop       (pop),
    .empty     (empty),
    .res_o     (res)
  );

  assign sent_count_o     = res.sent;
  assign recv_count_o     = res.recv;
  assign loss_centi_pct_o = res.loss;
  assign latest_valid_o   = res.latest_valid;
  assign latest_rtt_o     = res.latest_rtt;
  assign stats_valid_o    = res.stats_valid;
  assign min_rtt_o        = res.min_rtt;
  assign max_rtt_o        = res.max_rtt;
  assign mean_rtt_o       = res.mean_rtt;
  assign std_rtt_o        = res.std_rtt;
  assign saturated_o      = res.saturated;

endmodule

### verif/rtt_loss_statistics_checker.sv
`timescale 1ns / 1ps

// Watches the request and result channels of the probe statistics block,
// keeps its own copy of the running statistics and compares every result.
module rtt_loss_statistics_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  logic        op_i,
  input  logic        rtt_valid_i,
  input  logic [23:0] rtt_us_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  logic [15:0] sent_count_i,
  input  logic [15:0] recv_count_i,
  input  logic [13:0] loss_centi_pct_i,
  input  logic        latest_valid_i,
  input  logic [23:0] latest_rtt_i,
  input  logic        stats_valid_i,
  input  logic [23:0] min_rtt_i,
  input  logic [23:0] max_rtt_i,
  input  logic [23:0] mean_rtt_i,
  input  logic [23:0] std_rtt_i,
  input  logic        saturated_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          result_count_o
);

  // Predicted running history of the probes.
  logic [rls_pkg::CountBits-1:0] probes_sent;
  logic [rls_pkg::CountBits-1:0] replies_seen;
  logic [rls_pkg::SumBits-1:0]   time_sum;
  logic [rls_pkg::SqBits-1:0]    time_sq_sum;
  logic [rls_pkg::RttBits-1:0]   fastest;
  logic [rls_pkg::RttBits-1:0]   slowest;
  logic                          last_reply;
  logic [rls_pkg::RttBits-1:0]   last_time;
  logic                          count_full;

  rls_pkg::res_t awaited_stats[$];

  // Integer square root by the digit-by-digit method.
  function automatic logic [63:0] root_of(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Applies one request to the predicted history and returns its result.
  function automatic rls_pkg::res_t probe_summary(input logic op, input logic rv,
                                                  input logic [rls_pkg::RttBits-1:0] t);
    rls_pkg::res_t s;
    logic [63:0] mean;
    logic [63:0] sq_mean;
    if (op == rls_pkg::OpClear) begin
      probes_sent = '0;
      replies_seen = '0;
      time_sum = '0;
      time_sq_sum = '0;
      fastest = '0;
      slowest = '0;
      last_reply = 1'b0;
      last_time = '0;
      count_full = 1'b0;
    end else if (probes_sent < rls_pkg::CountMax) begin
      probes_sent = probes_sent + 1'b1;
      if (rv) begin
        if (replies_seen == '0) begin
          fastest = t;
          slowest = t;
        end else begin
          if (t < fastest) fastest = t;
          if (t > slowest) slowest = t;
        end
        replies_seen = replies_seen + 1'b1;
        time_sum = time_sum + rls_pkg::SumBits'(t);
        time_sq_sum = time_sq_sum + 64'(t) * 64'(t);
        last_reply = 1'b1;
        last_time = t;
      end else begin
        last_reply = 1'b0;
        last_time = '0;
      end
      if (probes_sent >= rls_pkg::CountMax) count_full = 1'b1;
    end
    s = '0;
    s.sent = probes_sent;
    s.recv = replies_seen;
    if (probes_sent != '0)
      s.loss = rls_pkg::LossBits'((64'(probes_sent - replies_seen) * 64'd10000)
                                  / 64'(probes_sent));
    s.latest_valid = last_reply;
    s.latest_rtt = last_time;
    s.stats_valid = replies_seen != '0;
    s.saturated = count_full;
    if (replies_seen != '0) begin
      s.min_rtt = fastest;
      s.max_rtt = slowest;
      mean = 64'(time_sum) / 64'(replies_seen);
      sq_mean = time_sq_sum / 64'(replies_seen);
      s.mean_rtt = rls_pkg::RttBits'(mean);
      if (sq_mean > mean * mean)
        s.std_rtt = rls_pkg::RttBits'(root_of(sq_mean - mean * mean));
    end
    return s;
  endfunction

  // Reports one field that differs from the prediction.
  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  // Predict on every accepted request and check every accepted result.
  always @(posedge clk_i or negedge rst_ni) begin
    rls_pkg::res_t w;
    if (!rst_ni) begin
      probes_sent = '0;
      replies_seen = '0;
      time_sum = '0;
      time_sq_sum = '0;
      fastest = '0;
      slowest = '0;
      last_reply = 1'b0;
      last_time = '0;
      count_full = 1'b0;
      awaited_stats.delete();
      fail_count_o = 0;
      result_count_o = 0;
      pending_o = 0;
    end else begin
      if (push_i && !full_i)
        awaited_stats.insert(awaited_stats.size(),
                             probe_summary(op_i, rtt_valid_i, rtt_us_i));
      if (pop_i && !empty_i) begin
        result_count_o++;
        if (awaited_stats.size() == 0) begin
          $error("result with no request waiting");
          fail_count_o++;
        end else begin
          w = awaited_stats[0];
          awaited_stats.delete(0);
          compare_field("sent_count", w.sent, sent_count_i);
          compare_field("recv_count", w.recv, recv_count_i);
          compare_field("loss_centi_pct", w.loss, loss_centi_pct_i);
          compare_field("latest_valid", w.latest_valid, latest_valid_i);
          compare_field("latest_rtt", w.latest_rtt, latest_rtt_i);
          compare_field("stats_valid", w.stats_valid, stats_valid_i);
          compare_field("min_rtt", w.min_rtt, min_rtt_i);
          compare_field("max_rtt", w.max_rtt, max_rtt_i);
          compare_field("mean_rtt", w.mean_rtt, mean_rtt_i);
          compare_field("std_rtt", w.std_rtt, std_rtt_i);
          compare_field("saturated", w.saturated, saturated_i);
        end
      end
      pending_o = awaited_stats.size();
    end
  end

endmodule

### verif/rtt_loss_statistics_test.sv
`timescale 1ns / 1ps

module rtt_loss_statistics_test;

  localparam int IdleLimit = 20000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        push = 0;
  logic        full;
  logic        op_i = rls_pkg::OpSample;
  logic        rtt_valid_i = 0;
  logic [23:0] rtt_us_i = 0;
  logic        empty;
  logic        pop = 0;
  logic [15:0] sent_count_o;
  logic [15:0] recv_count_o;
  logic [13:0] loss_centi_pct_o;
  logic        latest_valid_o;
  logic [23:0] latest_rtt_o;
  logic        stats_valid_o;
  logic [23:0] min_rtt_o;
  logic [23:0] max_rtt_o;
  logic [23:0] mean_rtt_o;
  logic [23:0] std_rtt_o;
  logic        saturated_o;
  int          fail_count;
  int          pending;
  int          result_count;
  int          request_count = 0;
  int          quiet_cycles = 0;
  int          clears_sent = 0;
  bit          long_hold_done = 0;

  always #5 clk_i = ~clk_i;

  rtt_loss_statistics dut (.*);

  rtt_loss_statistics_checker checker_inst (
    .clk_i, .rst_ni, .push_i(push), .full_i(full), .op_i, .rtt_valid_i,
    .rtt_us_i, .empty_i(empty), .pop_i(pop), .sent_count_i(sent_count_o),
    .recv_count_i(recv_count_o), .loss_centi_pct_i(loss_centi_pct_o),
    .latest_valid_i(latest_valid_o), .latest_rtt_i(latest_rtt_o),
    .stats_valid_i(stats_valid_o), .min_rtt_i(min_rtt_o), .max_rtt_i(max_rtt_o),
    .mean_rtt_i(mean_rtt_o), .std_rtt_i(std_rtt_o), .saturated_i(saturated_o),
    .fail_count_o(fail_count), .pending_o(pending), .result_count_o(result_count)
  );

  // Offers one request after gap idle cycles and holds it until the block
  // takes it; push stays high afterwards so that a following request with
  // no gap goes back to back.
  task automatic send_request(input logic op, input logic rv, input logic [23:0] t,
                              input int gap);
    repeat (gap) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    op_i <= op;
    rtt_valid_i <= rv;
    rtt_us_i <= t;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    request_count++;
    if (op == rls_pkg::OpClear) clears_sent++;
  endtask

  // Random reply time: small, mid-range, fully random or near the maximum.
  function automatic logic [23:0] random_time();
    case ($urandom_range(0, 3))
      0: return 24'($urandom_range(0, 255));
      1: return 24'($urandom_range(1000, 200000));
      2: return 24'($urandom);
      default: return 24'($urandom_range(16777000, 16777215));
    endcase
  endfunction

  // Result side: random stalls, one long hold-off once the run is under way.
  initial begin
    int wait_n;
    @(posedge rst_ni);
    forever begin
      if (!long_hold_done && request_count > 40) begin
        long_hold_done = 1;
        pop <= 1'b0;
        repeat (2000) @(posedge clk_i);
      end
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      repeat (wait_n) begin
        pop <= 1'b0;
        @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
    end
  end

  // Watchdog on cycles with no accepted request or result.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > IdleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Stimulus: directed corners, then random probes with clears.
  initial begin
    int burst;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Extremes, losses, clears and a mean square equal to the squared mean.
    send_request(rls_pkg::OpSample, 0, 24'h0, 0);
    send_request(rls_pkg::OpSample, 1, 24'hFFFFFF, 0);
    send_request(rls_pkg::OpSample, 1, 24'h0, 0);
    send_request(rls_pkg::OpSample, 1, 24'hFFFFFF, 0);
    send_request(rls_pkg::OpSample, 0, 24'hABCDEF, 0);
    send_request(rls_pkg::OpClear, 1, 24'hFFFFFF, 0);
    send_request(rls_pkg::OpSample, 1, 24'd5, 0);
    send_request(rls_pkg::OpSample, 1, 24'd6, 0);
    send_request(rls_pkg::OpSample, 1, 24'd6, 0);
    send_request(rls_pkg::OpSample, 1, 24'h555555, 0);
    send_request(rls_pkg::OpSample, 1, 24'hAAAAAA, 0);
    send_request(rls_pkg::OpClear, 0, 24'h0, 0);
    send_request(rls_pkg::OpClear, 0, 24'h0, 0);
    send_request(rls_pkg::OpSample, 0, 24'h0, 0);
    send_request(rls_pkg::OpSample, 1, 24'd1, 0);

    // Sender pauses until every result has come back.
    push <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);

    // Random part, with clears now and then; bursts keep the gap at zero.
    while (request_count < 1050) begin
      burst = $urandom_range(0, 7);
      if ($urandom_range(0, 39) == 0)
        send_request(rls_pkg::OpClear, 1'($urandom_range(0, 1)), 24'($urandom),
                     $urandom_range(0, 16));
      else
        send_request(rls_pkg::OpSample, $urandom_range(0, 4) != 0, random_time(),
                     burst == 0 ? 0 : $urandom_range(0, 16));
    end

    // A clear followed straight away by a single reply.
    send_request(rls_pkg::OpClear, 0, 24'h0, 0);
    send_request(rls_pkg::OpSample, 1, 24'd7, 0);
    push <= 1'b0;
    @(posedge clk_i);

    wait (pending == 0);
    repeat (400) @(posedge clk_i);
    $display("Sent %0d requests including %0d clears, checked %0d results.",
             request_count, clears_sent, result_count);
    $display("Covered field extremes, losses, clears, bursts and a long result stall.");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### files.f
design/rls_pkg.sv
design/rls_front.sv
design/rls_queue.sv
design/rls_back.sv
design/rtt_loss_statistics.sv
verif/rtt_loss_statistics_checker.sv
verif/rtt_loss_statistics_test.sv
